// ===== sv/lppd_pkg.sv =====
package lppd_pkg;

   localparam int SENSOR_COUNT = 11;
   localparam int CENTER_COUNT = SENSOR_COUNT - 2;
   localparam int MID_SENSOR = (SENSOR_COUNT - 1) / 2;

   localparam int LEVEL_W = 10;
   localparam int ERR_W = 5;
   localparam int GAIN_W = 16;
   localparam int COUNT_W = 10;
   localparam int INTEG_W = 16;
   localparam int MEDIUM_W = 8;
   localparam int RECOVERY_W = 7;
   localparam int DUTY_W = 8;
   localparam int DRIVE_W = 2;
   localparam int SIDE_W = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_LINE       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CORNER_THRESHOLD  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEDIUM_SPEED      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECOVERY_SPEED    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_P            = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_I            = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_D            = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEGRAL_INTERVAL = 3'd7;

   localparam logic [DRIVE_W-1:0] DRIVE_BRAKE   = 2'd0;
   localparam logic [DRIVE_W-1:0] DRIVE_FORWARD = 2'd1;
   localparam logic [DRIVE_W-1:0] DRIVE_REVERSE = 2'd2;

   localparam logic [SIDE_W-1:0] SIDE_CENTER = 2'd0;
   localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 2'd1;
   localparam logic [SIDE_W-1:0] SIDE_LEFT   = 2'd2;

   localparam logic signed [ERR_W-1:0] CENTER_ERR_LO = -5'sd4;
   localparam logic signed [ERR_W-1:0] CENTER_ERR_HI = 5'sd4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                         invert_line;
      logic [LEVEL_W-1:0]           corner_threshold;
      logic signed [MEDIUM_W-1:0]   medium_speed;
      logic [RECOVERY_W-1:0]        recovery_speed;
      logic [GAIN_W-1:0]            gain_p;
      logic [GAIN_W-1:0]            gain_i;
      logic [GAIN_W-1:0]            gain_d;
      logic [COUNT_W-1:0]           integral_interval;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      invert_line:       1'b0,
      corner_threshold:  10'd200,
      medium_speed:      8'sd50,
      recovery_speed:    7'd100,
      gain_p:            16'd160,
      gain_i:            16'd0,
      gain_d:            16'd0,
      integral_interval: 10'd350
   };

   typedef struct packed {
      logic                      on_line;
      logic signed [ERR_W-1:0]   err;
   } sample_type;

endpackage

// ===== sv/lppd_if.sv =====
interface lppd_req_if import lppd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CENTER_COUNT-1:0]  center_levels;
   logic [LEVEL_W-1:0]       left_corner_level;
   logic [LEVEL_W-1:0]       right_corner_level;

   modport source (output valid, center_levels, left_corner_level, right_corner_level,
                   input ready);
   modport sink (input valid, center_levels, left_corner_level, right_corner_level,
                 output ready);
endinterface

interface lppd_rsp_if import lppd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [DUTY_W-1:0]         left_duty;
   logic [DRIVE_W-1:0]        left_drive;
   logic [DUTY_W-1:0]         right_duty;
   logic [DRIVE_W-1:0]        right_drive;
   logic signed [ERR_W-1:0]   position_error;
   logic                      off_line;

   modport source (output valid, left_duty, left_drive, right_duty, right_drive,
                   position_error, off_line, input ready);
   modport sink (input valid, left_duty, left_drive, right_duty, right_drive,
                 position_error, off_line, output ready);
endinterface

// ===== sv/lppd_front.sv =====
module lppd_front import lppd_pkg::*; (
   lppd_req_if.sink     req,
   input  cfg_type      cfg,
   input  logic         queue_full,
   output logic         push,
   output sample_type   sample
);

   logic [SENSOR_COUNT-1:0] seen;
   logic                    left_high;
   logic                    right_high;

   assign req.ready = !queue_full;
   assign push = req.valid && !queue_full;

   assign left_high = req.left_corner_level > cfg.corner_threshold;
   assign right_high = req.right_corner_level > cfg.corner_threshold;

   // normalize every sensor to "sees the line"
   always_comb begin
      seen[0] = left_high ^ !cfg.invert_line;
      seen[SENSOR_COUNT-1] = right_high ^ !cfg.invert_line;
      for (int k = 1; k < SENSOR_COUNT - 1; k++) begin
         seen[k] = req.center_levels[k-1] ^ !cfg.invert_line;
      end
   end

   // priority chain, later matches win
   always_comb begin
      int e;
      e = 0;
      for (int k = 1; k <= MID_SENSOR; k++) begin
         if (seen[MID_SENSOR-k]) e = -2 * k;
      end
      for (int k = 1; k < MID_SENSOR; k++) begin
         if (seen[MID_SENSOR-k] && seen[MID_SENSOR-k-1]) e = -(2 * k + 1);
      end
      for (int k = 1; MID_SENSOR + k <= SENSOR_COUNT - 1; k++) begin
         if (seen[MID_SENSOR+k]) e = 2 * k;
      end
      for (int k = 1; MID_SENSOR + k + 1 <= SENSOR_COUNT - 1; k++) begin
         if (seen[MID_SENSOR+k] && seen[MID_SENSOR+k+1]) e = 2 * k + 1;
      end
      if (seen[MID_SENSOR]) e = 0;
      if (seen[MID_SENSOR] && seen[MID_SENSOR-1]) e = -1;
      if (seen[MID_SENSOR] && seen[MID_SENSOR+1]) e = 1;
      sample.err = ERR_W'(e);
      sample.on_line = |seen;
   end

endmodule

// ===== sv/lppd_queue.sv =====
module lppd_queue import lppd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  sample_type   push_data,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output sample_type   head
);

   sample_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic [QUEUE_CNT_W-1:0]   count_in;
   logic                     do_pop;

   assign full = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head = mem_ff[rd_ptr_ff];
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/lppd_back.sv =====
module lppd_back import lppd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         head_valid,
   input  sample_type   head,
   output logic         pop,
   lppd_rsp_if.source   rsp
);

   localparam int DIFF_W = ERR_W + 1;
   localparam int SPEED_W = 9;
   localparam int T_W = SPEED_W + 1;
   localparam int MAG_W = SPEED_W;
   localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
   localparam int PROD_I_W = GAIN_W + 1 + INTEG_W;
   localparam int PROD_D_W = GAIN_W + 1 + DIFF_W;
   localparam int ACC_W = PROD_I_W + 2;
   localparam int PID_W = ACC_W - 4;
   localparam int SUM_W = PID_W + 1;
   localparam int SPEED_LIMIT = 200;
   localparam int SPEED_OFFSET = 100;
   localparam int ROUND_BIAS = 15;
   // 51/20 as a fixed-point reciprocal, exact for magnitudes up to 300
   localparam int RECIP_MUL = 167127;
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W = 27;
   localparam int Q_W = 10;
   localparam int M_W = Q_W + 1;
   localparam int DUTY_MAX = 255;
   localparam logic signed [INTEG_W:0] INTEG_HI = (INTEG_W + 1)'((1 << (INTEG_W - 1)) - 1);
   localparam logic signed [INTEG_W:0] INTEG_LO = -(INTEG_W + 1)'(1 << (INTEG_W - 1));

   typedef struct packed {
      logic                        on_line;
      logic signed [ERR_W-1:0]     err;
      logic signed [SPEED_W-1:0]   off_l;
      logic signed [SPEED_W-1:0]   off_r;
   } carry_type;

   typedef struct packed {
      logic [DUTY_W-1:0]    duty;
      logic [DRIVE_W-1:0]   mode;
   } wheel_type;

   function automatic logic signed [SPEED_W-1:0] clamp_speed(
      input logic signed [SUM_W-1:0] s
   );
      logic signed [SPEED_W-1:0] r;
      if (s > SUM_W'(SPEED_LIMIT)) r = SPEED_W'(SPEED_LIMIT);
      else if (s < -SUM_W'(SPEED_LIMIT)) r = -SPEED_W'(SPEED_LIMIT);
      else r = SPEED_W'(s);
      return r;
   endfunction

   function automatic wheel_type map_wheel(input logic [Q_W-1:0] q, input logic neg);
      logic signed [M_W-1:0] m;
      logic signed [M_W-1:0] mag;
      wheel_type w;
      m = (neg ? -M_W'(q) : M_W'(q)) - M_W'(DUTY_MAX);
      mag = (m < 0) ? -m : m;
      if (m == 0) begin
         w.duty = DUTY_W'(DUTY_MAX);
         w.mode = DRIVE_BRAKE;
      end else begin
         w.duty = (mag > M_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : DUTY_W'(mag);
         w.mode = (m > 0) ? DRIVE_FORWARD : DRIVE_REVERSE;
      end
      return w;
   endfunction

   // pid state
   logic [SIDE_W-1:0]          side_ff, side_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic signed [ERR_W-1:0]    last_ff, last_in;
   logic signed [INTEG_W-1:0]  integ_ff, integ_in;

   logic                       advance;
   logic [COUNT_W:0]           count_next;
   logic signed [INTEG_W:0]    integ_sum;
   logic signed [INTEG_W-1:0]  integ_sat;
   carry_type                  carry_in;

   // stage registers
   logic                       s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                       s5_valid_ff, s6_valid_ff, s7_valid_ff;
   carry_type                  s1_carry_ff, s2_carry_ff, s3_carry_ff, s4_carry_ff;
   logic                       s5_on_ff, s6_on_ff;
   logic signed [ERR_W-1:0]    s5_err_ff, s6_err_ff;
   logic signed [INTEG_W-1:0]  s1_integ_ff;
   logic signed [DIFF_W-1:0]   s1_diff_ff;
   logic signed [PROD_P_W-1:0] s2_prod_p_ff;
   logic signed [PROD_I_W-1:0] s2_prod_i_ff;
   logic signed [PROD_D_W-1:0] s2_prod_d_ff;
   logic signed [ACC_W-1:0]    s3_acc_ff;
   logic signed [PID_W-1:0]    s4_pid_ff;
   logic signed [T_W-1:0]      s5_t_l_ff, s5_t_r_ff;
   logic [Q_W-1:0]             s6_q_l_ff, s6_q_r_ff;
   logic                       s6_neg_l_ff, s6_neg_r_ff;
   wheel_type                  s7_left_ff, s7_right_ff;
   logic signed [ERR_W-1:0]    s7_err_ff;
   logic                       s7_off_ff;

   logic signed [ACC_W-1:0]    acc_adj;
   logic signed [SUM_W-1:0]    sum_l, sum_r;
   logic signed [SPEED_W-1:0]  speed_l, speed_r;
   logic [MAG_W-1:0]           mag_l, mag_r;
   logic [RECIP_W-1:0]         recip_l, recip_r;

   // whole back pipeline stalls together on a held result
   assign advance = !s7_valid_ff || rsp.ready;
   assign pop = advance && head_valid;

   // stage one: pid state update, in item order
   always_comb begin
      side_in = side_ff;
      count_in = count_ff;
      last_in = last_ff;
      integ_in = integ_ff;
      count_next = {1'b0, count_ff} + 1'b1;
      integ_sum = (INTEG_W + 1)'(integ_ff) + (INTEG_W + 1)'(head.err);
      if (integ_sum > INTEG_HI) begin
         integ_sat = INTEG_W'(INTEG_HI);
      end else if (integ_sum < INTEG_LO) begin
         integ_sat = INTEG_W'(INTEG_LO);
      end else begin
         integ_sat = INTEG_W'(integ_sum);
      end
      if (pop && head.on_line) begin
         if (head.err >= CENTER_ERR_LO && head.err <= CENTER_ERR_HI) side_in = SIDE_CENTER;
         else if (head.err > CENTER_ERR_HI) side_in = SIDE_LEFT;
         else side_in = SIDE_RIGHT;
         if (count_next > {1'b0, cfg.integral_interval}) begin
            count_in = '0;
            last_in = head.err;
            integ_in = integ_sat;
         end else begin
            count_in = count_next[COUNT_W-1:0];
         end
         if (head.err == '0) integ_in = '0;
      end
   end

   // off-line speeds from the side remembered before this item
   always_comb begin
      carry_in.on_line = head.on_line;
      carry_in.err = head.err;
      unique case (side_ff)
         SIDE_CENTER: begin
            carry_in.off_l = SPEED_W'(cfg.medium_speed);
            carry_in.off_r = SPEED_W'(cfg.medium_speed);
         end
         SIDE_LEFT: begin
            carry_in.off_l = SPEED_W'(cfg.recovery_speed);
            carry_in.off_r = -SPEED_W'(cfg.recovery_speed);
         end
         SIDE_RIGHT: begin
            carry_in.off_l = -SPEED_W'(cfg.recovery_speed);
            carry_in.off_r = SPEED_W'(cfg.recovery_speed);
         end
         default: begin
            carry_in.off_l = '0;
            carry_in.off_r = '0;
         end
      endcase
   end

   always_comb begin
      acc_adj = s3_acc_ff + (s3_acc_ff[ACC_W-1] ? ACC_W'(ROUND_BIAS) : ACC_W'(0));
      sum_l = SUM_W'(cfg.medium_speed) + SUM_W'(s4_pid_ff);
      sum_r = SUM_W'(cfg.medium_speed) - SUM_W'(s4_pid_ff);
      speed_l = s4_carry_ff.on_line ? clamp_speed(sum_l) : s4_carry_ff.off_l;
      speed_r = s4_carry_ff.on_line ? clamp_speed(sum_r) : s4_carry_ff.off_r;
      mag_l = MAG_W'(s5_t_l_ff[T_W-1] ? -s5_t_l_ff : s5_t_l_ff);
      mag_r = MAG_W'(s5_t_r_ff[T_W-1] ? -s5_t_r_ff : s5_t_r_ff);
      recip_l = RECIP_W'(mag_l) * RECIP_W'(RECIP_MUL);
      recip_r = RECIP_W'(mag_r) * RECIP_W'(RECIP_MUL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SIDE_CENTER;
         count_ff <= '0;
         last_ff <= '0;
         integ_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else begin
         side_ff <= side_in;
         count_ff <= count_in;
         last_ff <= last_in;
         integ_ff <= integ_in;
         if (advance) begin
            s1_valid_ff <= head_valid;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            s4_valid_ff <= s3_valid_ff;
            s5_valid_ff <= s4_valid_ff;
            s6_valid_ff <= s5_valid_ff;
            s7_valid_ff <= s6_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_carry_ff <= carry_in;
         s1_integ_ff <= integ_ff;
         s1_diff_ff <= DIFF_W'(head.err) - DIFF_W'(last_ff);

         s2_carry_ff <= s1_carry_ff;
         s2_prod_p_ff <= PROD_P_W'($signed({1'b0, cfg.gain_p})) * PROD_P_W'(s1_carry_ff.err);
         s2_prod_i_ff <= PROD_I_W'($signed({1'b0, cfg.gain_i})) * PROD_I_W'(s1_integ_ff);
         s2_prod_d_ff <= PROD_D_W'($signed({1'b0, cfg.gain_d})) * PROD_D_W'(s1_diff_ff);

         s3_carry_ff <= s2_carry_ff;
         s3_acc_ff <= ACC_W'(s2_prod_p_ff) + ACC_W'(s2_prod_i_ff) + ACC_W'(s2_prod_d_ff);

         // divide by 16 rounding toward zero
         s4_carry_ff <= s3_carry_ff;
         s4_pid_ff <= PID_W'(acc_adj >>> 4);

         s5_on_ff <= s4_carry_ff.on_line;
         s5_err_ff <= s4_carry_ff.err;
         s5_t_l_ff <= T_W'(speed_l) + T_W'(SPEED_OFFSET);
         s5_t_r_ff <= T_W'(speed_r) + T_W'(SPEED_OFFSET);

         s6_on_ff <= s5_on_ff;
         s6_err_ff <= s5_err_ff;
         s6_q_l_ff <= Q_W'(recip_l >> RECIP_SHIFT);
         s6_q_r_ff <= Q_W'(recip_r >> RECIP_SHIFT);
         s6_neg_l_ff <= s5_t_l_ff[T_W-1];
         s6_neg_r_ff <= s5_t_r_ff[T_W-1];

         s7_left_ff <= map_wheel(s6_q_l_ff, s6_neg_l_ff);
         s7_right_ff <= map_wheel(s6_q_r_ff, s6_neg_r_ff);
         s7_err_ff <= s6_err_ff;
         s7_off_ff <= !s6_on_ff;
      end
   end

   assign rsp.valid = s7_valid_ff;
   assign rsp.left_duty = s7_left_ff.duty;
   assign rsp.left_drive = s7_left_ff.mode;
   assign rsp.right_duty = s7_right_ff.duty;
   assign rsp.right_drive = s7_right_ff.mode;
   assign rsp.position_error = s7_err_ff;
   assign rsp.off_line = s7_off_ff;

endmodule

// ===== sv/line_position_pid_drive.sv =====
// channel   dir   carries
// req_ch    in    center_levels, left_corner_level, right_corner_level
// rsp_ch    out   left/right duty and drive, position_error, off_line
// csr_*     in    write enable, 3-bit register index, 16-bit write data
//
// one item per clock sustained while rsp_ch is not held; a result shows on rsp_ch once its
// item is taken and has passed one queue entry, then the seven-stage back pipeline: state,
// multiply, sum, scale, speed, reciprocal multiply, drive map
// the pid state is read and written in the first back stage, so items follow back to back
// reset clears registers to their defaults, the pid state and every valid bit
// a held rsp_ch freezes the back pipeline; the two-entry queue takes req_ch items until full
module line_position_pid_drive import lppd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   lppd_req_if.sink                 req_ch,
   lppd_rsp_if.source               rsp_ch,
   input  logic                     csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_write_data
);

   cfg_type      cfg_ff;
   cfg_type      cfg_in;
   logic         queue_full;
   logic         push;
   sample_type   push_data;
   logic         pop;
   logic         head_valid;
   sample_type   head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_INVERT_LINE:       cfg_in.invert_line = csr_write_data[0];
            CSR_CORNER_THRESHOLD:  cfg_in.corner_threshold = csr_write_data[LEVEL_W-1:0];
            CSR_MEDIUM_SPEED:      cfg_in.medium_speed = csr_write_data[MEDIUM_W-1:0];
            CSR_RECOVERY_SPEED:    cfg_in.recovery_speed = csr_write_data[RECOVERY_W-1:0];
            CSR_GAIN_P:            cfg_in.gain_p = csr_write_data[GAIN_W-1:0];
            CSR_GAIN_I:            cfg_in.gain_i = csr_write_data[GAIN_W-1:0];
            CSR_GAIN_D:            cfg_in.gain_d = csr_write_data[GAIN_W-1:0];
            CSR_INTEGRAL_INTERVAL: cfg_in.integral_interval = csr_write_data[COUNT_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lppd_front u_front (
      .req        (req_ch),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .sample     (push_data)
   );

   lppd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   lppd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp        (rsp_ch)
   );

endmodule

// ===== sim/line_position_pid_drive_test.sv =====
`timescale 1ns / 1ps

module line_position_pid_drive_test;
   import lppd_pkg::*;

   localparam int LEVEL_MAX = (1 << LEVEL_W) - 1;
   localparam int WIND_RUN = 8;

   typedef struct packed {
      logic [CENTER_COUNT-1:0]  center_levels;
      logic [LEVEL_W-1:0]       left_corner_level;
      logic [LEVEL_W-1:0]       right_corner_level;
   } line_sample_type;

   typedef struct packed {
      logic [DUTY_W-1:0]        left_duty;
      logic [DRIVE_W-1:0]       left_drive;
      logic [DUTY_W-1:0]        right_duty;
      logic [DRIVE_W-1:0]       right_drive;
      logic signed [ERR_W-1:0]  position_error;
      logic                     off_line;
   } wheel_command_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                    csr_write_enable;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_write_data;

   lppd_req_if req_ch ();
   lppd_rsp_if rsp_ch ();

   line_position_pid_drive uut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // predictor copy of registers and steering state
   cfg_type            cfg;
   logic [SIDE_W-1:0]  pred_side;
   int                 pred_count;
   int                 pred_last_err;
   int                 pred_integral;

   line_sample_type    pending_samples[$];
   wheel_command_type  expected_commands[$];

   bit    idling_on;
   bit    long_hold_wanted;
   logic  long_hold_on;
   int    send_gap;
   int    recv_gap;
   int    error_count;
   int    sent_count;
   int    checked_count;
   int    settings_count;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at result %0d: %s got %0d expected %0d", checked_count, what, got, want);
      error_count++;
   endtask

   function automatic void map_speed(input longint speed, output logic [DUTY_W-1:0] duty,
                                     output logic [DRIVE_W-1:0] mode);
      longint m;
      m = ((speed + 100) * 510) / 200 - 255;
      if (m == 0) begin
         duty = 8'd255;
         mode = DRIVE_BRAKE;
      end else if (m > 0) begin
         duty = (m > 255) ? 8'd255 : DUTY_W'(m);
         mode = DRIVE_FORWARD;
      end else begin
         duty = (m < -255) ? 8'd255 : DUTY_W'(-m);
         mode = DRIVE_REVERSE;
      end
   endfunction

   // works out the wheel command for one sample and advances the pid state
   function automatic wheel_command_type steer(input line_sample_type smp);
      logic [SENSOR_COUNT-1:0] seen;
      bit                 any_seen;
      bit                 lhi;
      bit                 rhi;
      int                 err;
      int                 k;
      int                 c;
      int                 cnt;
      int                 sum;
      longint             acc;
      longint             pid;
      longint             left_speed;
      longint             right_speed;
      wheel_command_type  r;
      c = MID_SENSOR;
      lhi = smp.left_corner_level > cfg.corner_threshold;
      rhi = smp.right_corner_level > cfg.corner_threshold;
      seen[0] = cfg.invert_line ? lhi : !lhi;
      seen[SENSOR_COUNT-1] = cfg.invert_line ? rhi : !rhi;
      for (k = 1; k < SENSOR_COUNT - 1; k++)
         seen[k] = cfg.invert_line ? smp.center_levels[k-1] : !smp.center_levels[k-1];
      any_seen = |seen;
      err = 0;
      left_speed = 0;
      right_speed = 0;
      if (!any_seen) begin
         case (pred_side)
            SIDE_CENTER: begin
               left_speed = longint'(cfg.medium_speed);
               right_speed = longint'(cfg.medium_speed);
            end
            SIDE_LEFT: begin
               left_speed = longint'(cfg.recovery_speed);
               right_speed = -longint'(cfg.recovery_speed);
            end
            SIDE_RIGHT: begin
               left_speed = -longint'(cfg.recovery_speed);
               right_speed = longint'(cfg.recovery_speed);
            end
            default: ;
         endcase
      end else begin
         // later rules override earlier ones
         for (k = 1; k <= c; k++)
            if (seen[c-k]) err = -2 * k;
         for (k = 1; k < c; k++)
            if (seen[c-k] && seen[c-k-1]) err = -(2 * k + 1);
         for (k = 1; c + k <= SENSOR_COUNT - 1; k++)
            if (seen[c+k]) err = 2 * k;
         for (k = 1; c + k + 1 <= SENSOR_COUNT - 1; k++)
            if (seen[c+k] && seen[c+k+1]) err = 2 * k + 1;
         if (seen[c]) err = 0;
         if (seen[c] && seen[c-1]) err = -1;
         if (seen[c] && seen[c+1]) err = 1;

         if (err >= int'(CENTER_ERR_LO) && err <= int'(CENTER_ERR_HI)) pred_side = SIDE_CENTER;
         else if (err > int'(CENTER_ERR_HI)) pred_side = SIDE_LEFT;
         else pred_side = SIDE_RIGHT;

         acc = longint'(cfg.gain_p) * err + longint'(cfg.gain_i) * pred_integral
             + longint'(cfg.gain_d) * (err - pred_last_err);
         pid = acc / 16;

         cnt = pred_count + 1;
         if (cnt > int'(cfg.integral_interval)) begin
            pred_count = 0;
            pred_last_err = err;
            sum = pred_integral + err;
            if (sum > 32767) sum = 32767;
            if (sum < -32768) sum = -32768;
            pred_integral = sum;
         end else begin
            pred_count = cnt % 1024;
         end
         if (err == 0) pred_integral = 0;

         left_speed = longint'(cfg.medium_speed) + pid;
         right_speed = longint'(cfg.medium_speed) - pid;
      end
      map_speed(left_speed, r.left_duty, r.left_drive);
      map_speed(right_speed, r.right_duty, r.right_drive);
      r.position_error = ERR_W'(err);
      r.off_line = !any_seen;
      return r;
   endfunction

   // sender: feeds pending samples, random gap bursts when idling is on
   always @(posedge clock) begin : sender
      logic offer;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_commands.push_back(steer(pending_samples.pop_front()));
            sent_count++;
         end
         offer = 1'b0;
         if (req_ch.valid && !req_ch.ready) begin
            offer = 1'b1;
         end else if (send_gap > 0) begin
            send_gap--;
         end else if (pending_samples.size() > 0) begin
            if (idling_on && $urandom_range(0, 11) == 0) send_gap = $urandom_range(0, 7);
            else offer = 1'b1;
         end
         req_ch.valid <= offer;
         if (offer && !(req_ch.valid && !req_ch.ready)) begin
            req_ch.center_levels <= pending_samples[0].center_levels;
            req_ch.left_corner_level <= pending_samples[0].left_corner_level;
            req_ch.right_corner_level <= pending_samples[0].right_corner_level;
         end
      end
   end

   // receiver: checks each command against the oldest prediction
   always @(posedge clock) begin : receiver
      wheel_command_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_commands.size() == 0) begin
               report_mismatch("item with nothing expected, position_error",
                               int'(rsp_ch.position_error), 0);
            end else begin
               want = expected_commands.pop_front();
               if (rsp_ch.left_duty !== want.left_duty)
                  report_mismatch("left_duty", int'(rsp_ch.left_duty), int'(want.left_duty));
               if (rsp_ch.left_drive !== want.left_drive)
                  report_mismatch("left_drive", int'(rsp_ch.left_drive),
                                  int'(want.left_drive));
               if (rsp_ch.right_duty !== want.right_duty)
                  report_mismatch("right_duty", int'(rsp_ch.right_duty),
                                  int'(want.right_duty));
               if (rsp_ch.right_drive !== want.right_drive)
                  report_mismatch("right_drive", int'(rsp_ch.right_drive),
                                  int'(want.right_drive));
               if (rsp_ch.position_error !== want.position_error)
                  report_mismatch("position_error", int'(rsp_ch.position_error),
                                  int'(want.position_error));
               if (rsp_ch.off_line !== want.off_line)
                  report_mismatch("off_line", int'(rsp_ch.off_line), int'(want.off_line));
            end
            checked_count++;
         end
         if (long_hold_on) begin
            rsp_ch.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ch.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(0, 7);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // long output hold so the block backs up and stalls its input
   initial begin : long_hold
      long_hold_on = 1'b0;
      wait (long_hold_wanted);
      @(posedge clock);
      long_hold_on <= 1'b1;
      repeat (64) @(posedge clock);
      long_hold_on <= 1'b0;
   end

   initial begin : watchdog
      #1_000_000;
      $display("line_position_pid_drive test failed");
      $finish;
   end

   function automatic logic [LEVEL_W-1:0] corner_level(input bit high);
      int thr;
      thr = int'(cfg.corner_threshold);
      if (high && thr < LEVEL_MAX)
         return ($urandom_range(0, 3) == 0) ? LEVEL_W'(thr + 1)
                                            : LEVEL_W'($urandom_range(thr + 1, LEVEL_MAX));
      if (high)
         return LEVEL_W'(LEVEL_MAX);
      return ($urandom_range(0, 3) == 0) ? LEVEL_W'(thr) : LEVEL_W'($urandom_range(0, thr));
   endfunction

   // raw levels for a given set of sensors that see the line, under current polarity
   function automatic line_sample_type make_sample(input logic [SENSOR_COUNT-1:0] seen);
      line_sample_type s;
      int k;
      s.left_corner_level = corner_level(cfg.invert_line ? seen[0] : !seen[0]);
      s.right_corner_level = corner_level(cfg.invert_line ? seen[SENSOR_COUNT-1]
                                                          : !seen[SENSOR_COUNT-1]);
      for (k = 1; k < SENSOR_COUNT - 1; k++)
         s.center_levels[k-1] = cfg.invert_line ? seen[k] : !seen[k];
      return s;
   endfunction

   function automatic logic [GAIN_W-1:0] random_gain();
      case ($urandom_range(0, 2))
         0: return GAIN_W'($urandom_range(0, 64));
         1: return GAIN_W'($urandom_range(0, 2000));
         default: return GAIN_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      c.invert_line = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: c.corner_threshold = '0;
         1: c.corner_threshold = LEVEL_W'(LEVEL_MAX);
         default: c.corner_threshold = LEVEL_W'($urandom_range(0, LEVEL_MAX));
      endcase
      c.medium_speed = MEDIUM_W'(int'($urandom_range(0, 200)) - 100);
      c.recovery_speed = RECOVERY_W'($urandom_range(0, 100));
      c.gain_p = random_gain();
      c.gain_i = random_gain();
      c.gain_d = random_gain();
      c.integral_interval = ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom_range(0, 1023))
                                                        : COUNT_W'($urandom_range(0, 8));
      return c;
   endfunction

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
   endtask

   task automatic apply_settings(input cfg_type c);
      write_register(CSR_INVERT_LINE, CSR_DATA_W'(c.invert_line));
      write_register(CSR_CORNER_THRESHOLD, CSR_DATA_W'(c.corner_threshold));
      write_register(CSR_MEDIUM_SPEED, CSR_DATA_W'(c.medium_speed[MEDIUM_W-1:0]));
      write_register(CSR_RECOVERY_SPEED, CSR_DATA_W'(c.recovery_speed));
      write_register(CSR_GAIN_P, c.gain_p);
      write_register(CSR_GAIN_I, c.gain_i);
      write_register(CSR_GAIN_D, c.gain_d);
      write_register(CSR_INTEGRAL_INTERVAL, CSR_DATA_W'(c.integral_interval));
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg = c;
      settings_count++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (pending_samples.size() != 0 || expected_commands.size() != 0)
         @(negedge clock);
   endtask

   // mostly a line under one to three adjacent sensors, some off line, some noise
   task automatic queue_random(input int n);
      int i;
      int w;
      int pick;
      line_sample_type s;
      for (i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            w = $urandom_range(1, 3);
            s = make_sample(SENSOR_COUNT'(((1 << w) - 1) << $urandom_range(0, SENSOR_COUNT - w)));
         end else if (pick < 75) begin
            s = make_sample('0);
         end else if (pick < 85) begin
            s = make_sample(SENSOR_COUNT'($urandom_range(0, (1 << SENSOR_COUNT) - 1)));
         end else begin
            s.center_levels = CENTER_COUNT'($urandom_range(0, (1 << CENTER_COUNT) - 1));
            s.left_corner_level = LEVEL_W'($urandom_range(0, LEVEL_MAX));
            s.right_corner_level = LEVEL_W'($urandom_range(0, LEVEL_MAX));
         end
         pending_samples.push_back(s);
      end
   endtask

   initial begin : stimulus
      int i;
      req_ch.valid = 1'b0;
      req_ch.center_levels = '0;
      req_ch.left_corner_level = '0;
      req_ch.right_corner_level = '0;
      rsp_ch.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      cfg = CFG_RESET;
      pred_side = SIDE_CENTER;
      pred_count = 0;
      pred_last_err = 0;
      pred_integral = 0;
      idling_on = 1'b1;
      long_hold_wanted = 1'b0;
      send_gap = 0;
      recv_gap = 0;
      error_count = 0;
      sent_count = 0;
      checked_count = 0;
      settings_count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: each error rule, recovery sides, raw extremes, threshold boundary
      pending_samples.push_back(make_sample(11'h000));
      pending_samples.push_back(make_sample(11'h020));
      pending_samples.push_back(make_sample(11'h030));
      pending_samples.push_back(make_sample(11'h060));
      pending_samples.push_back(make_sample(11'h001));
      pending_samples.push_back(make_sample(11'h003));
      pending_samples.push_back(make_sample(11'h400));
      pending_samples.push_back(make_sample(11'h600));
      pending_samples.push_back(make_sample(11'h008));
      pending_samples.push_back(make_sample(11'h00c));
      pending_samples.push_back(make_sample(11'h000));
      pending_samples.push_back(make_sample(11'h100));
      pending_samples.push_back(make_sample(11'h000));
      pending_samples.push_back(make_sample(11'h7ff));
      pending_samples.push_back('{9'h1ff, 10'h3ff, 10'h3ff});
      pending_samples.push_back('{9'h000, 10'h000, 10'h000});
      pending_samples.push_back('{9'h155, 10'd200, 10'd201});
      pending_samples.push_back('{9'h0aa, 10'd201, 10'd200});
      wait_drained();

      apply_settings('{invert_line: 1'b1, corner_threshold: 10'd0, medium_speed: -8'sd100,
                       recovery_speed: 7'd0, gain_p: 16'd0, gain_i: 16'd0, gain_d: 16'd0,
                       integral_interval: 10'd0});
      queue_random(100);
      wait_drained();

      apply_settings('{invert_line: 1'b0, corner_threshold: 10'd1023, medium_speed: 8'sd100,
                       recovery_speed: 7'd100, gain_p: 16'hffff, gain_i: 16'hffff,
                       gain_d: 16'hffff, integral_interval: 10'd1023});
      queue_random(100);
      wait_drained();

      // tuned loop, with a full drain half way through
      apply_settings('{invert_line: 1'b0, corner_threshold: 10'd300, medium_speed: 8'sd45,
                       recovery_speed: 7'd80, gain_p: 16'd240, gain_i: 16'd2, gain_d: 16'd600,
                       integral_interval: 10'd3});
      queue_random(100);
      wait_drained();
      queue_random(100);
      wait_drained();

      // back up the block: steady offers while the output is held
      idling_on = 1'b0;
      apply_settings(random_settings());
      queue_random(150);
      long_hold_wanted = 1'b1;
      wait_drained();
      idling_on = 1'b1;

      for (i = 0; i < 6; i++) begin
         apply_settings(random_settings());
         queue_random(100);
         wait_drained();
      end

      // last part without idling: wind the integral up on each side in turn
      idling_on = 1'b0;
      apply_settings('{invert_line: 1'b0, corner_threshold: 10'd512, medium_speed: 8'sd0,
                       recovery_speed: 7'd60, gain_p: 16'd7, gain_i: 16'hffff, gain_d: 16'd3,
                       integral_interval: 10'd0});
      for (i = 0; i < WIND_RUN; i++)
         pending_samples.push_back(make_sample(11'h400));
      pending_samples.push_back(make_sample(11'h020));
      for (i = 0; i < WIND_RUN; i++)
         pending_samples.push_back(make_sample(11'h001));
      pending_samples.push_back(make_sample(11'h000));
      wait_drained();

      repeat (30) @(posedge clock);
      $display("%0d samples sent under %0d register settings, %0d commands checked,",
               sent_count, settings_count + 1, checked_count);
      $display("%0d mismatches", error_count);
      $display("covered polarity and threshold extremes, recovery spins, output backpressure,");
      $display("and the error integral wound up on both sides at full integral gain");
      if (error_count == 0 && expected_commands.size() == 0) begin
         $display("line_position_pid_drive test passed");
      end else begin
         $display("line_position_pid_drive test failed");
      end
      $finish;
   end

endmodule
